// File: sv/spi_pkg.sv
// spi_pkg: shared constants, codes and types of the segment pair intersection block
// used by every module of the block except spi_div; depends on nothing
package spi_pkg;

   localparam int COORD_BITS_DEFAULT = 32;
   localparam int FRAC_BITS_DEFAULT  = 16;
   localparam int QUEUE_DEPTH        = 8;
   localparam int PRODUCT_ONE        = 65536;
   localparam int PORT_COORD_BITS    = 32;
   localparam int PORT_PARAM_BITS    = 17;
   localparam int TOL_BITS           = 16;
   localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd1;

   localparam logic [1:0] STATUS_NONE     = 2'd0;
   localparam logic [1:0] STATUS_HIT      = 2'd1;
   localparam logic [1:0] STATUS_PARALLEL = 2'd2;

   typedef enum logic [1:0] {
      KIND_SINGLE,
      KIND_CROSS,
      KIND_COLIN
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [1:0] status;
      logic [3:0] mask;
   } job_type;

   typedef struct packed {
      logic reject;
      logic a_point;
      logic b_point;
      logic b3_off;
      logic b4_off;
   } flag_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_CROSS_A,
      BK_CROSS_B,
      BK_COLIN
   } back_state_type;

   // first set mask bit at or above from: {found, index}
   function automatic logic [2:0] next_slot(input logic [3:0] mask, input logic [2:0] from);
      logic       found;
      logic [1:0] idx;
      found = 1'b0;
      idx   = 2'd0;
      for (int i = 0; i < 4; i++) begin
         if (!found && mask[i] && (3'(i) >= from)) begin
            found = 1'b1;
            idx   = 2'(i);
         end
      end
      return {found, idx};
   endfunction

endpackage

// File: sv/segment_pair_intersection.sv
// segment_pair_intersection: top level, tolerance register, front, job queue and back
// depends on spi_pkg, spi_front, spi_queue, spi_back
//
// A segment pair is transferred at a rising edge with start high and busy low.
// Results leave on the rsp_ ports, each valid for exactly one cycle under rsp_valid;
// rsp_last_result marks the final result of a pair. The receiver cannot stall.
// csr_write_enable writes csr_write_data into the near tolerance register.
// The front pipeline takes one pair a cycle while busy is low and classifies it in
// registered stages (coordinates, differences, products, sums); classified jobs wait
// in an eight-entry queue. busy rises when queue and pipeline together hold eight pairs.
// A single-result outcome (no hit, parallel, points) needs no division.
// Each quotient comes from the one shared radix-2 divider of the back end, which
// finishes sooner when the quotient saturates: a crossing needs two quotients in turn,
// a collinear overlap one per result; single-result pairs one cycle each.
// The divider sets the sustained rate.
// Reset (synchronous) empties pipeline and queue and sets the tolerance to 1.
module segment_pair_intersection #(
   parameter int COORD_BITS      = spi_pkg::COORD_BITS_DEFAULT,
   parameter int PARAM_FRAC_BITS = spi_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [spi_pkg::PORT_COORD_BITS-1:0] req_a_start_x,
   input  logic [spi_pkg::PORT_COORD_BITS-1:0] req_a_start_y,
   input  logic [spi_pkg::PORT_COORD_BITS-1:0] req_a_end_x,
   input  logic [spi_pkg::PORT_COORD_BITS-1:0] req_a_end_y,
   input  logic [spi_pkg::PORT_COORD_BITS-1:0] req_b_start_x,
   input  logic [spi_pkg::PORT_COORD_BITS-1:0] req_b_start_y,
   input  logic [spi_pkg::PORT_COORD_BITS-1:0] req_b_end_x,
   input  logic [spi_pkg::PORT_COORD_BITS-1:0] req_b_end_y,
   input  logic                                csr_write_enable,
   input  logic [spi_pkg::TOL_BITS-1:0]        csr_write_data,
   output logic                                rsp_valid,
   output logic [1:0]                          rsp_status,
   output logic [spi_pkg::PORT_PARAM_BITS-1:0] rsp_param_on_a,
   output logic [spi_pkg::PORT_PARAM_BITS-1:0] rsp_param_on_b,
   output logic                                rsp_last_result
);
   localparam int PW    = 2 * (COORD_BITS + 1) + 2;
   localparam int DEPTH = spi_pkg::QUEUE_DEPTH;
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int SW    = CW + 1;

   logic [spi_pkg::TOL_BITS-1:0]          tol_ff;
   logic [7:0][spi_pkg::PORT_COORD_BITS-1:0] pts;
   logic                                  accept, push, pop, empty;
   spi_pkg::job_type                      job_push, job_head;
   logic [3:0][PW-1:0]                    nums_push, nums_head;
   logic [1:0][PW-1:0]                    dens_push, dens_head;
   logic [2:0]                            inflight;
   logic [CW-1:0]                         count;

   always_ff @(posedge clock) begin
      if (reset) tol_ff <= spi_pkg::TOL_RESET;
      else if (csr_write_enable) tol_ff <= csr_write_data;
   end

   assign pts = {req_b_end_y, req_b_end_x, req_b_start_y, req_b_start_x,
                 req_a_end_y, req_a_end_x, req_a_start_y, req_a_start_x};
   assign busy   = (SW'(count) + SW'(inflight)) >= SW'(DEPTH);
   assign accept = start && !busy;

   spi_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .pts_in   (pts),
      .tol      (tol_ff),
      .push     (push),
      .job      (job_push),
      .nums     (nums_push),
      .dens     (dens_push),
      .inflight (inflight)
   );

   spi_queue #(.DEPTH(DEPTH), .DATA_BITS(6 * PW)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .job_in   (job_push),
      .data_in  ({nums_push, dens_push}),
      .pop      (pop),
      .job_out  (job_head),
      .data_out ({nums_head, dens_head}),
      .empty    (empty),
      .count    (count)
   );

   spi_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(PARAM_FRAC_BITS)) u_back (
      .clock           (clock),
      .reset           (reset),
      .empty           (empty),
      .job             (job_head),
      .nums            (nums_head),
      .dens            (dens_head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_param_on_a  (rsp_param_on_a),
      .rsp_param_on_b  (rsp_param_on_b),
      .rsp_last_result (rsp_last_result)
   );

`ifndef ASSERT_OFF
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != spi_pkg::STATUS_HIT |-> rsp_last_result)
      else $error("non-hit result not marked last");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && count == CW'(DEPTH) |-> pop)
      else $error("job queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty job queue");
   a_credit: assert property (@(posedge clock) disable iff (reset)
      (SW'(count) + SW'(inflight)) <= SW'(DEPTH))
      else $error("queue credit exceeded");
`endif

endmodule

// File: sv/spi_front.sv
// spi_front: four-stage front pipeline, bounding box, cross and dot products, classification
// depends on spi_pkg
module spi_front #(
   parameter int COORD_BITS = spi_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             accept,
   input  logic [7:0][spi_pkg::PORT_COORD_BITS-1:0]         pts_in,
   input  logic [spi_pkg::TOL_BITS-1:0]                     tol,
   output logic                                             push,
   output spi_pkg::job_type                                 job,
   output logic [3:0][2*(2*(COORD_BITS+1))+4-2*(COORD_BITS+1)-3:0] nums,
   output logic [1:0][2*(2*(COORD_BITS+1))+4-2*(COORD_BITS+1)-3:0] dens,
   output logic [2:0]                                       inflight
);
   localparam int W  = COORD_BITS;
   localparam int DW = W + 1;
   localparam int MW = 2 * DW;
   localparam int PW = MW + 2;

   logic                 v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [W-1:0]  pt_ff [8];
   logic signed [W-1:0]  x1, y1, x2, y2, x3, y3, x4, y4;
   logic signed [W-1:0]  lox, hix, loy, hiy;
   logic                 rejx, rejy;
   logic signed [DW-1:0] ax_ff, ay_ff, bx_ff, by_ff, cx_ff, cy_ff, gx_ff, gy_ff, hx_ff, hy_ff;
   spi_pkg::flag_type    fl2_in, fl2_ff, fl3_ff, fl4_ff;
   logic signed [MW-1:0] pr_in [20];
   logic signed [MW-1:0] pr_ff [20];
   logic signed [PW-1:0] sm_in [10];
   logic signed [PW-1:0] sm_ff [10];
   logic signed [PW-1:0] d, f, e, c, lb, la, tol_s, one_s;
   logic [3:0]           mask;

   function automatic logic signed [MW-1:0] mul(input logic signed [DW-1:0] a,
                                                input logic signed [DW-1:0] b);
      return MW'(a) * MW'(b);
   endfunction

   function automatic logic [PW-1:0] mag(input logic signed [PW-1:0] v);
      return (v < 0) ? -v : v;
   endfunction

   assign x1 = pt_ff[0];
   assign y1 = pt_ff[1];
   assign x2 = pt_ff[2];
   assign y2 = pt_ff[3];
   assign x3 = pt_ff[4];
   assign y3 = pt_ff[5];
   assign x4 = pt_ff[6];
   assign y4 = pt_ff[7];

   // stage one: coordinates
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < 8; i++) pt_ff[i] <= pts_in[i][W-1:0];
      end
   end

   // stage two: differences and box test
   always_comb begin
      lox  = (x2 < x1) ? x2 : x1;
      hix  = (x2 < x1) ? x1 : x2;
      loy  = (y2 < y1) ? y2 : y1;
      hiy  = (y2 < y1) ? y1 : y2;
      rejx = (x3 > x4) ? (hix < x4 || lox > x3) : (hix < x3 || lox > x4);
      rejy = (y3 > y4) ? (hiy < y4 || loy > y3) : (hiy < y3 || loy > y4);
      fl2_in.reject  = rejx || rejy;
      fl2_in.a_point = (x1 == x2) && (y1 == y2);
      fl2_in.b_point = (x3 == x4) && (y3 == y4);
      fl2_in.b3_off  = !(x3 == x2 && y3 == y2) && !(x3 == x1 && y3 == y1);
      fl2_in.b4_off  = !(x4 == x2 && y4 == y2) && !(x4 == x1 && y4 == y1);
   end

   always_ff @(posedge clock) begin
      ax_ff  <= DW'(x2) - DW'(x1);
      ay_ff  <= DW'(y2) - DW'(y1);
      bx_ff  <= DW'(x3) - DW'(x4);
      by_ff  <= DW'(y3) - DW'(y4);
      cx_ff  <= DW'(x1) - DW'(x3);
      cy_ff  <= DW'(y1) - DW'(y3);
      gx_ff  <= DW'(x2) - DW'(x3);
      gy_ff  <= DW'(y2) - DW'(y3);
      hx_ff  <= DW'(x4) - DW'(x1);
      hy_ff  <= DW'(y4) - DW'(y1);
      fl2_ff <= fl2_in;
   end

   // stage three: products
   always_comb begin
      pr_in[0]  = mul(by_ff, cx_ff);
      pr_in[1]  = mul(bx_ff, cy_ff);
      pr_in[2]  = mul(ay_ff, bx_ff);
      pr_in[3]  = mul(ax_ff, by_ff);
      pr_in[4]  = mul(ax_ff, cy_ff);
      pr_in[5]  = mul(ay_ff, cx_ff);
      pr_in[6]  = mul(ax_ff, hy_ff);
      pr_in[7]  = mul(ay_ff, hx_ff);
      pr_in[8]  = mul(bx_ff, bx_ff);
      pr_in[9]  = mul(by_ff, by_ff);
      pr_in[10] = mul(cx_ff, bx_ff);
      pr_in[11] = mul(cy_ff, by_ff);
      pr_in[12] = mul(gx_ff, bx_ff);
      pr_in[13] = mul(gy_ff, by_ff);
      pr_in[14] = mul(ax_ff, ax_ff);
      pr_in[15] = mul(ay_ff, ay_ff);
      pr_in[16] = mul(cx_ff, ax_ff);
      pr_in[17] = mul(cy_ff, ay_ff);
      pr_in[18] = mul(hx_ff, ax_ff);
      pr_in[19] = mul(hy_ff, ay_ff);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 20; i++) pr_ff[i] <= pr_in[i];
      fl3_ff <= fl2_ff;
   end

   // stage four: cross and dot sums
   always_comb begin
      sm_in[0] = PW'(pr_ff[0]) - PW'(pr_ff[1]);
      sm_in[1] = PW'(pr_ff[2]) - PW'(pr_ff[3]);
      sm_in[2] = PW'(pr_ff[4]) - PW'(pr_ff[5]);
      sm_in[3] = PW'(pr_ff[6]) - PW'(pr_ff[7]);
      sm_in[4] = PW'(pr_ff[8]) + PW'(pr_ff[9]);
      sm_in[5] = -(PW'(pr_ff[10]) + PW'(pr_ff[11]));
      sm_in[6] = -(PW'(pr_ff[12]) + PW'(pr_ff[13]));
      sm_in[7] = PW'(pr_ff[14]) + PW'(pr_ff[15]);
      sm_in[8] = -(PW'(pr_ff[16]) + PW'(pr_ff[17]));
      sm_in[9] = PW'(pr_ff[18]) + PW'(pr_ff[19]);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 10; i++) sm_ff[i] <= sm_in[i];
      fl4_ff <= fl3_ff;
   end

   // classification
   assign d     = sm_ff[0];
   assign f     = sm_ff[1];
   assign e     = sm_ff[2];
   assign c     = sm_ff[3];
   assign lb    = sm_ff[4];
   assign la    = sm_ff[7];
   assign tol_s = PW'({1'b0, tol});
   assign one_s = PW'(spi_pkg::PRODUCT_ONE);

   always_comb begin
      mask[0] = (lb != 0) && (sm_ff[5] >= 0) && (sm_ff[5] <= lb);
      mask[1] = (lb != 0) && (sm_ff[6] >= 0) && (sm_ff[6] <= lb);
      mask[2] = (la != 0) && fl4_ff.b3_off && (sm_ff[8] >= 0) && (sm_ff[8] <= la);
      mask[3] = (la != 0) && fl4_ff.b4_off && (sm_ff[9] >= 0) && (sm_ff[9] <= la);
      job.kind   = spi_pkg::KIND_SINGLE;
      job.status = spi_pkg::STATUS_NONE;
      job.mask   = 4'd0;
      nums[0] = sm_ff[5];
      nums[1] = sm_ff[6];
      nums[2] = sm_ff[8];
      nums[3] = sm_ff[9];
      dens[0] = lb;
      dens[1] = la;
      if (fl4_ff.reject) begin
         job.kind = spi_pkg::KIND_SINGLE;
      end else if (f != 0) begin
         if ((f > 0) && (d < 0 || d - f > tol_s || e < 0 || e - f > tol_s)) begin
            job.kind = spi_pkg::KIND_SINGLE;
         end else if ((f < 0) && (d > 0 || f - d > tol_s || e > 0 || f - e > tol_s)) begin
            job.kind = spi_pkg::KIND_SINGLE;
         end else begin
            job.kind = spi_pkg::KIND_CROSS;
            nums[0]  = mag(d);
            nums[1]  = mag(e);
            dens[0]  = mag(f);
         end
      end else if (d < 0 || d > one_s || e < 0 || e > one_s) begin
         job.kind = spi_pkg::KIND_SINGLE;
      end else if (fl4_ff.a_point && fl4_ff.b_point) begin
         job.status = spi_pkg::STATUS_HIT;
      end else if (c != 0) begin
         job.status = spi_pkg::STATUS_PARALLEL;
      end else if (mask != 4'd0) begin
         job.kind = spi_pkg::KIND_COLIN;
         job.mask = mask;
      end
   end

   assign push     = v4_ff;
   assign inflight = {2'b0, v1_ff} + {2'b0, v2_ff} + {2'b0, v3_ff} + {2'b0, v4_ff};

endmodule

// File: sv/spi_queue.sv
// spi_queue: short job queue between front and back
// depends on spi_pkg
module spi_queue #(
   parameter int DEPTH = spi_pkg::QUEUE_DEPTH,
   parameter int DATA_BITS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  spi_pkg::job_type             job_in,
   input  logic [DATA_BITS-1:0]         data_in,
   input  logic                         pop,
   output spi_pkg::job_type             job_out,
   output logic [DATA_BITS-1:0]         data_out,
   output logic                         empty,
   output logic [$clog2(DEPTH+1)-1:0]   count
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   spi_pkg::job_type     job_mem [DEPTH];
   logic [DATA_BITS-1:0] data_mem [DEPTH];
   logic [AW-1:0]        wr_ff, rd_ff;
   logic [CW-1:0]        count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         if (pop)  rd_ff <= (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         if (push && !pop) count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         job_mem[wr_ff]  <= job_in;
         data_mem[wr_ff] <= data_in;
      end
   end

   assign job_out  = job_mem[rd_ff];
   assign data_out = data_mem[rd_ff];
   assign empty    = (count_ff == '0);
   assign count    = count_ff;

endmodule

// File: sv/spi_div.sv
// spi_div: restoring divider, one quotient bit a cycle, saturating at one
// depends on nothing
module spi_div #(
   parameter int NUM_BITS  = 68,
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_BITS-1:0]  num,
   input  logic [NUM_BITS-1:0]  den,
   output logic                 done,
   output logic [FRAC_BITS:0]   quotient
);
   localparam int CW = $clog2(FRAC_BITS + 1);

   logic [NUM_BITS:0]   rem_ff, shifted;
   logic [NUM_BITS-1:0] den_ff;
   logic [FRAC_BITS:0]  q_ff;
   logic [CW-1:0]       cnt_ff;
   logic                run_ff, done_ff;

   assign shifted = {rem_ff[NUM_BITS-1:0], 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= !(num >= den);
            done_ff <= (num >= den);
         end else if (run_ff && cnt_ff == CW'(1)) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         den_ff <= den;
         cnt_ff <= CW'(FRAC_BITS);
         rem_ff <= {1'b0, num};
         q_ff   <= (num >= den) ? {1'b1, {FRAC_BITS{1'b0}}} : '0;
      end else if (run_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (shifted >= {1'b0, den_ff}) begin
            rem_ff <= shifted - {1'b0, den_ff};
            q_ff   <= {q_ff[FRAC_BITS-1:0], 1'b1};
         end else begin
            rem_ff <= shifted;
            q_ff   <= {q_ff[FRAC_BITS-1:0], 1'b0};
         end
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// File: sv/spi_back.sv
// spi_back: back sequencer, takes jobs from the queue, runs the divider, drives results
// depends on spi_pkg and spi_div
module spi_back #(
   parameter int COORD_BITS = spi_pkg::COORD_BITS_DEFAULT,
   parameter int FRAC_BITS  = spi_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       empty,
   input  spi_pkg::job_type                           job,
   input  logic [3:0][2*(COORD_BITS+1)+1:0]           nums,
   input  logic [1:0][2*(COORD_BITS+1)+1:0]           dens,
   output logic                                       pop,
   output logic                                       rsp_valid,
   output logic [1:0]                                 rsp_status,
   output logic [spi_pkg::PORT_PARAM_BITS-1:0]        rsp_param_on_a,
   output logic [spi_pkg::PORT_PARAM_BITS-1:0]        rsp_param_on_b,
   output logic                                       rsp_last_result
);
   localparam int PW = 2 * (COORD_BITS + 1) + 2;
   localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   spi_pkg::back_state_type state_ff, state_in;
   logic [1:0]          slot_ff, slot_in, slot_sel;
   logic [FRAC_BITS:0]  qa_ff, qa_in, pa_ff, pa_in, pb_ff, pb_in, q;
   logic [1:0]          st_ff, st_in;
   logic                val_ff, val_in, last_ff, last_in;
   logic                div_start, done;
   logic [2:0]          first, nxt;
   logic [PW-1:0]       div_num, div_den;

   spi_div #(.NUM_BITS(PW), .FRAC_BITS(FRAC_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (div_num),
      .den      (div_den),
      .done     (done),
      .quotient (q)
   );

   assign first   = spi_pkg::next_slot(job.mask, 3'd0);
   assign nxt     = spi_pkg::next_slot(job.mask, {1'b0, slot_ff} + 3'd1);
   assign div_num = nums[slot_sel];
   assign div_den = dens[slot_sel[1]];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spi_pkg::BK_IDLE;
         val_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         val_ff   <= val_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      qa_ff   <= qa_in;
      pa_ff   <= pa_in;
      pb_ff   <= pb_in;
      st_ff   <= st_in;
      last_ff <= last_in;
   end

   always_comb begin
      state_in  = state_ff;
      slot_in   = slot_ff;
      slot_sel  = slot_ff;
      qa_in     = qa_ff;
      pop       = 1'b0;
      div_start = 1'b0;
      val_in    = 1'b0;
      st_in     = st_ff;
      pa_in     = pa_ff;
      pb_in     = pb_ff;
      last_in   = last_ff;
      unique case (state_ff)
         spi_pkg::BK_IDLE: begin
            if (!empty) begin
               unique case (job.kind)
                  spi_pkg::KIND_CROSS: begin
                     div_start = 1'b1;
                     slot_sel  = 2'd0;
                     state_in  = spi_pkg::BK_CROSS_A;
                  end
                  spi_pkg::KIND_COLIN: begin
                     div_start = 1'b1;
                     slot_sel  = first[1:0];
                     slot_in   = first[1:0];
                     state_in  = spi_pkg::BK_COLIN;
                  end
                  default: begin
                     val_in  = 1'b1;
                     st_in   = job.status;
                     pa_in   = '0;
                     pb_in   = '0;
                     last_in = 1'b1;
                     pop     = 1'b1;
                  end
               endcase
            end
         end
         spi_pkg::BK_CROSS_A: begin
            slot_sel = 2'd1;
            if (done) begin
               qa_in     = q;
               div_start = 1'b1;
               state_in  = spi_pkg::BK_CROSS_B;
            end
         end
         spi_pkg::BK_CROSS_B: begin
            if (done) begin
               val_in   = 1'b1;
               st_in    = spi_pkg::STATUS_HIT;
               pa_in    = qa_ff;
               pb_in    = q;
               last_in  = 1'b1;
               pop      = 1'b1;
               state_in = spi_pkg::BK_IDLE;
            end
         end
         spi_pkg::BK_COLIN: begin
            if (done) begin
               val_in  = 1'b1;
               st_in   = spi_pkg::STATUS_HIT;
               last_in = !nxt[2];
               case (slot_ff)
                  2'd0:    begin pa_in = '0;  pb_in = q;   end
                  2'd1:    begin pa_in = ONE; pb_in = q;   end
                  2'd2:    begin pa_in = q;   pb_in = '0;  end
                  default: begin pa_in = q;   pb_in = ONE; end
               endcase
               if (nxt[2]) begin
                  div_start = 1'b1;
                  slot_sel  = nxt[1:0];
                  slot_in   = nxt[1:0];
               end else begin
                  pop      = 1'b1;
                  state_in = spi_pkg::BK_IDLE;
               end
            end
         end
         default: state_in = spi_pkg::BK_IDLE;
      endcase
   end

   assign rsp_valid       = val_ff;
   assign rsp_status      = st_ff;
   assign rsp_param_on_a  = spi_pkg::PORT_PARAM_BITS'(pa_ff);
   assign rsp_param_on_b  = spi_pkg::PORT_PARAM_BITS'(pb_ff);
   assign rsp_last_result = last_ff;

endmodule
